/* sv/scls_pkg.sv */
// Shared types and constants for the step charge level selector.
package scls_pkg;

   // operation codes carried in the request word
   localparam logic [1:0] OP_CHECK = 2'd0;
   localparam logic [1:0] OP_RESET = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   // table selectors for a table write
   localparam logic [2:0] TBL_VOLTAGE = 3'd0;
   localparam logic [2:0] TBL_CURRENT = 3'd1;
   localparam logic [2:0] TBL_SOC     = 3'd2;
   localparam logic [2:0] TBL_FAST    = 3'd3;
   localparam logic [2:0] TBL_FLOAT   = 3'd4;

   // register indexes on the csr port
   localparam logic [1:0] REG_MODE      = 2'd0;
   localparam logic [1:0] REG_POWER_THR = 2'd1;
   localparam logic [1:0] REG_STEP_CNT  = 2'd2;

   // mode bit masks
   localparam logic [6:0] MODE_VOLTAGE  = 7'h01;
   localparam logic [6:0] MODE_SOC      = 7'h02;
   localparam logic [6:0] MODE_POWER    = 7'h04;
   localparam logic [6:0] MODE_CABLE    = 7'h08;
   localparam logic [6:0] MODE_FLOAT    = 7'h20;
   localparam logic [6:0] MODE_CURRENT  = 7'h40;
   localparam logic [6:0] MODE_ANY_CRIT = 7'h43;

   localparam logic [16:0] VOLT_MARGIN = 17'd20;

   localparam logic [15:0] POWER_THR_RESET = 16'd20000;

   typedef struct packed {
      logic [6:0]  mode_bits;
      logic [15:0] power_threshold;
      logic [3:0]  step_count;
   } cfg_type;

   typedef struct packed {
      logic capture;   // latch the accepted word, start the walk
      logic advance;   // move the walk to the next step
      logic commit;    // update selection and load the result word
   } cmd_type;

   typedef struct packed {
      logic check_go;  // accepted word is a check with gates open
      logic stop_any;  // an enabled criterion stops at the walk step
      logic at_last;   // walk step reached the last usable step
      logic selected;  // a step was selected before this word
   } status_type;

endpackage

/* sv/scls_csr.sv */
// Configuration registers behind the APB-style csr port.
module scls_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output scls_pkg::cfg_type    cfg
);
   import scls_pkg::*;

   logic [6:0]  mode_ff, mode_in;
   logic [15:0] power_thr_ff, power_thr_in;
   logic [3:0]  step_cnt_ff, step_cnt_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      mode_in      = mode_ff;
      power_thr_in = power_thr_ff;
      step_cnt_in  = step_cnt_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_MODE:      mode_in      = csr_pwdata[6:0];
            REG_POWER_THR: power_thr_in = csr_pwdata[15:0];
            REG_STEP_CNT:  step_cnt_in  = csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= '0;
         power_thr_ff <= POWER_THR_RESET;
         step_cnt_ff  <= '0;
      end else begin
         mode_ff      <= mode_in;
         power_thr_ff <= power_thr_in;
         step_cnt_ff  <= step_cnt_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MODE:      csr_prdata = {25'd0, mode_ff};
         REG_POWER_THR: csr_prdata = {16'd0, power_thr_ff};
         REG_STEP_CNT:  csr_prdata = {28'd0, step_cnt_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.mode_bits       = mode_ff;
   assign cfg.power_threshold = power_thr_ff;
   assign cfg.step_count      = step_cnt_ff;

endmodule

/* sv/scls_ctrl.sv */
// Controller: sequences accept, step walk and result hand-off.
module scls_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  scls_pkg::status_type   status,
   output scls_pkg::cmd_type      cmd
);
   import scls_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = status.check_go ? ST_WALK : ST_FIN;
            end
         end
         ST_WALK: begin
            // first stop of any criterion is the lowest candidate
            if (status.at_last || status.stop_any) begin
               state_in = ST_FIN;
            end else if (status.selected) begin
               cmd.advance = 1'b1;
               state_in    = ST_FIN;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* sv/scls_datapath.sv */
// Datapath: step tables, walk counter, selection state and result word.
module scls_datapath #(
   parameter int MAX_STEPS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  scls_pkg::cfg_type      cfg,
   input  scls_pkg::cmd_type      cmd,
   input  logic [1:0]             req_op,
   input  logic [2:0]             req_table_sel,
   input  logic [2:0]             req_table_index,
   input  logic [15:0]            req_table_value,
   input  logic [15:0]            req_chg_power,
   input  logic                   req_hv_cable,
   input  logic [15:0]            req_battery_voltage,
   input  logic signed [15:0]     req_battery_current,
   input  logic [9:0]             req_state_of_charge,
   input  logic                   req_no_swelling,
   output scls_pkg::status_type   status,
   output logic                   rsp_changed,
   output logic                   rsp_step_valid,
   output logic [2:0]             rsp_step_index,
   output logic [15:0]            rsp_fast_current,
   output logic                   rsp_float_update,
   output logic [15:0]            rsp_float_voltage
);
   import scls_pkg::*;

   localparam int SW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int CW = $clog2(MAX_STEPS + 1);

   logic [15:0] volt_tbl_ff  [MAX_STEPS];
   logic [15:0] cur_tbl_ff   [MAX_STEPS];
   logic [15:0] soc_tbl_ff   [MAX_STEPS];
   logic [15:0] fast_tbl_ff  [MAX_STEPS];
   logic [15:0] float_tbl_ff [MAX_STEPS];

   logic [15:0]        volt_ff;
   logic signed [15:0] cur_ff;
   logic [9:0]         soc_ff;
   logic               noswell_ff;
   logic [1:0]         op_ff;
   logic               walk_ff;

   logic [SW-1:0] step_ff, step_in;
   logic [SW-1:0] cur_step_ff, cur_step_in;
   logic          sel_ff, sel_in;

   logic [CW-1:0] cnt;
   logic [SW-1:0] last;
   logic          go;
   logic          wr_ok;
   logic [SW-1:0] wr_addr;
   logic          stop_v, stop_c, stop_s;
   logic          changed_n, fupd_n;

   // usable step count saturates at the table depth
   always_comb begin
      if (32'(cfg.step_count) > MAX_STEPS) cnt = CW'(MAX_STEPS);
      else                                 cnt = CW'(cfg.step_count);
      if (cnt != '0) last = SW'(cnt - 1'b1);
      else           last = '0;
   end

   always_comb begin
      go = (cfg.mode_bits != '0);
      if (((cfg.mode_bits & MODE_POWER) != '0) && (req_chg_power < cfg.power_threshold))
         go = 1'b0;
      if (((cfg.mode_bits & MODE_CABLE) != '0) && !req_hv_cable)
         go = 1'b0;
      if ((cfg.mode_bits & MODE_ANY_CRIT) == '0)
         go = 1'b0;
   end

   // per-criterion stop at the walk step; negative current stops as a huge unsigned value
   always_comb begin
      stop_v = ((cfg.mode_bits & MODE_VOLTAGE) != '0) &&
               (({1'b0, volt_ff} + VOLT_MARGIN) < {1'b0, volt_tbl_ff[step_ff]});
      stop_c = ((cfg.mode_bits & MODE_CURRENT) != '0) &&
               (cur_ff[15] || (16'(cur_ff) > cur_tbl_ff[step_ff]));
      stop_s = ((cfg.mode_bits & MODE_SOC) != '0) &&
               ({6'd0, soc_ff} < soc_tbl_ff[step_ff]);
   end

   assign status.check_go = (req_op == OP_CHECK) && go;
   assign status.stop_any = stop_v || stop_c || stop_s;
   assign status.at_last  = (step_ff >= last);
   assign status.selected = sel_ff;

   assign wr_ok   = cmd.capture && (req_op == OP_WRITE) && (32'(req_table_index) < MAX_STEPS);
   assign wr_addr = SW'(req_table_index);

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         case (req_table_sel)
            TBL_VOLTAGE: volt_tbl_ff[wr_addr]  <= req_table_value;
            TBL_CURRENT: cur_tbl_ff[wr_addr]   <= req_table_value;
            TBL_SOC:     soc_tbl_ff[wr_addr]   <= req_table_value;
            TBL_FAST:    fast_tbl_ff[wr_addr]  <= req_table_value;
            TBL_FLOAT:   float_tbl_ff[wr_addr] <= req_table_value;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         volt_ff    <= req_battery_voltage;
         cur_ff     <= req_battery_current;
         soc_ff     <= req_state_of_charge;
         noswell_ff <= req_no_swelling;
         op_ff      <= req_op;
         walk_ff    <= status.check_go;
      end
   end

   always_comb begin
      step_in = step_ff;
      if (cmd.capture)      step_in = sel_ff ? cur_step_ff : '0;
      else if (cmd.advance) step_in = step_ff + 1'b1;
   end

   assign changed_n = walk_ff && (!sel_ff || (step_ff != cur_step_ff));
   assign fupd_n    = changed_n && ((cfg.mode_bits & MODE_FLOAT) != '0) && noswell_ff;

   always_comb begin
      sel_in      = sel_ff;
      cur_step_in = cur_step_ff;
      if (cmd.commit) begin
         if (op_ff == OP_RESET) begin
            sel_in      = 1'b0;
            cur_step_in = '0;
         end else if (changed_n) begin
            sel_in      = 1'b1;
            cur_step_in = step_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= '0;
         cur_step_ff <= '0;
         sel_ff      <= 1'b0;
      end else begin
         step_ff     <= step_in;
         cur_step_ff <= cur_step_in;
         sel_ff      <= sel_in;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_changed       <= changed_n;
         rsp_step_valid    <= sel_in;
         rsp_step_index    <= 3'(cur_step_in);
         rsp_fast_current  <= changed_n ? fast_tbl_ff[step_ff] : 16'd0;
         rsp_float_update  <= fupd_n;
         rsp_float_voltage <= fupd_n ? float_tbl_ff[step_ff] : 16'd0;
      end
   end

endmodule

/* sv/step_charge_level_select_unit.sv */
// Top level of the step charge level selector.
// A check word with open gates walks the shared step counter until an enabled criterion
// stops or the last usable step is reached (at most one step past a held step); other words
// go straight to commit, which waits for a free result slot. New words wait for the commit.
// Reset (synchronous, active high): no step selected, step 0, mode 0, power threshold
// 20000, step count 0; step tables are not cleared and hold nothing until written.
module step_charge_level_select_unit #(
   parameter int MAX_STEPS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // table_index[2:0], table_value[18:3], chg_power[34:19], hv_cable[35],
   // battery_voltage[51:36], battery_current[67:52], state_of_charge[77:68],
   // no_swelling[78], zero fill[79]
   input  logic [79:0] req_tdata,
   // op[1:0], table_sel[4:2]
   input  logic [4:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // changed[0], step_valid[1], step_index[4:2], fast_current[20:5],
   // float_update[21], float_voltage[37:22], zero fill[39:38]
   output logic [39:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import scls_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   logic        rsp_changed;
   logic        rsp_step_valid;
   logic [2:0]  rsp_step_index;
   logic [15:0] rsp_fast_current;
   logic        rsp_float_update;
   logic [15:0] rsp_float_voltage;

   scls_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   scls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   scls_datapath #(
      .MAX_STEPS (MAX_STEPS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .cmd                 (cmd),
      .req_op              (req_tuser[1:0]),
      .req_table_sel       (req_tuser[4:2]),
      .req_table_index     (req_tdata[2:0]),
      .req_table_value     (req_tdata[18:3]),
      .req_chg_power       (req_tdata[34:19]),
      .req_hv_cable        (req_tdata[35]),
      .req_battery_voltage (req_tdata[51:36]),
      .req_battery_current (req_tdata[67:52]),
      .req_state_of_charge (req_tdata[77:68]),
      .req_no_swelling     (req_tdata[78]),
      .status              (status),
      .rsp_changed         (rsp_changed),
      .rsp_step_valid      (rsp_step_valid),
      .rsp_step_index      (rsp_step_index),
      .rsp_fast_current    (rsp_fast_current),
      .rsp_float_update    (rsp_float_update),
      .rsp_float_voltage   (rsp_float_voltage)
   );

   assign rsp_tdata = {2'b00, rsp_float_voltage, rsp_float_update, rsp_fast_current,
                       rsp_step_index, rsp_step_valid, rsp_changed};

endmodule

/* test/tb_step_charge_level_select_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the step charge level selector.
module tb_step_charge_level_select_unit;
   import scls_pkg::*;

   localparam int N_STEPS       = 8;
   localparam int RANDOM_WORDS  = 1300;
   localparam int IDLE_PCT      = 22;
   localparam int STALL_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 12;
   localparam logic [1:0] OP_IDLE = 2'd3;   // no operation, still answered

   typedef enum int {CRIT_VOLTAGE, CRIT_CURRENT, CRIT_SOC} crit_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [2:0]  sel;
      logic [2:0]  idx;
      logic [15:0] value;
      logic [15:0] power;
      logic        cable;
      logic [15:0] volt;
      logic [15:0] current;
      logic [9:0]  soc;
      logic        noswell;
   } req_word_type;

   typedef struct packed {
      logic        changed;
      logic        valid;
      logic [2:0]  idx;
      logic [15:0] fast;
      logic        fupd;
      logic [15:0] fvolt;
   } rsp_word_type;

   class charge_step_tracker;
      logic [6:0]  mode;
      logic [15:0] power_thr;
      logic [3:0]  step_cnt;
      logic [2:0]  cur_step;
      logic        selected;
      logic [15:0] volt_lim[N_STEPS];
      logic [15:0] cur_lim[N_STEPS];
      logic [15:0] soc_lim[N_STEPS];
      logic [15:0] fast_cur[N_STEPS];
      logic [15:0] float_volt[N_STEPS];
      rsp_word_type pending_steps[$];
      int errors, words, checks, changes;

      function new();
         mode = '0;
         power_thr = POWER_THR_RESET;
         step_cnt = '0;
         cur_step = '0;
         selected = 1'b0;
         errors = 0;
         words = 0;
         checks = 0;
         changes = 0;
      endfunction

      function void set_reg(logic [1:0] index, logic [31:0] val);
         case (index)
            REG_MODE:      mode = val[6:0];
            REG_POWER_THR: power_thr = val[15:0];
            REG_STEP_CNT:  step_cnt = val[3:0];
            default: ;
         endcase
      endfunction

      // one criterion: walk from start, at most one step when a step is already held
      function int walk(crit_type kind, int start, int last, logic [31:0] value);
         int s;
         logic stop;
         s = start;
         while (s < last) begin
            case (kind)
               CRIT_VOLTAGE: stop = (value + 32'(VOLT_MARGIN)) < {16'd0, volt_lim[s]};
               CRIT_CURRENT: stop = value > {16'd0, cur_lim[s]};
               default:      stop = value < {16'd0, soc_lim[s]};
            endcase
            if (stop) return s;
            s++;
            if (selected) return s;
         end
         return s;
      endfunction

      function rsp_word_type select_step(req_word_type w);
         rsp_word_type r;
         logic go, have;
         int cnt, last, start, step, c;
         r = '0;
         case (w.op)
            OP_RESET: begin
               selected = 1'b0;
               cur_step = '0;
            end
            OP_WRITE: begin
               case (w.sel)
                  TBL_VOLTAGE: volt_lim[w.idx] = w.value;
                  TBL_CURRENT: cur_lim[w.idx] = w.value;
                  TBL_SOC:     soc_lim[w.idx] = w.value;
                  TBL_FAST:    fast_cur[w.idx] = w.value;
                  TBL_FLOAT:   float_volt[w.idx] = w.value;
                  default: ;
               endcase
            end
            OP_CHECK: begin
               go = (mode != '0);
               if (go && (mode & MODE_POWER) != '0 && w.power < power_thr) go = 1'b0;
               if (go && (mode & MODE_CABLE) != '0 && !w.cable) go = 1'b0;
               if (go && (mode & MODE_ANY_CRIT) == '0) go = 1'b0;
               if (go) begin
                  cnt = (step_cnt > N_STEPS) ? N_STEPS : int'(step_cnt);
                  last = (cnt > 0) ? cnt - 1 : 0;
                  start = selected ? int'(cur_step) : 0;
                  have = 1'b0;
                  step = 0;
                  if ((mode & MODE_VOLTAGE) != '0) begin
                     step = walk(CRIT_VOLTAGE, start, last, {16'd0, w.volt});
                     have = 1'b1;
                  end
                  if ((mode & MODE_CURRENT) != '0) begin
                     // negative current seen as a huge unsigned value
                     c = walk(CRIT_CURRENT, start, last, {{16{w.current[15]}}, w.current});
                     if (!have || c < step) step = c;
                     have = 1'b1;
                  end
                  if ((mode & MODE_SOC) != '0) begin
                     c = walk(CRIT_SOC, start, last, {22'd0, w.soc});
                     if (!have || c < step) step = c;
                     have = 1'b1;
                  end
                  if (have && (!selected || step != int'(cur_step))) begin
                     r.changed = 1'b1;
                     cur_step = step[2:0];
                     selected = 1'b1;
                     r.fast = fast_cur[step];
                     if ((mode & MODE_FLOAT) != '0 && w.noswell) begin
                        r.fupd = 1'b1;
                        r.fvolt = float_volt[step];
                     end
                  end
               end
            end
            default: ;
         endcase
         r.valid = selected;
         r.idx = cur_step;
         return r;
      endfunction

      function void note_word(req_word_type w);
         pending_steps.push_back(select_step(w));
         words++;
         if (w.op == OP_CHECK) checks++;
      endfunction

      function void report(string name, logic [15:0] want, logic [15:0] got);
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      endfunction

      function void check_word(logic [39:0] data);
         rsp_word_type got, want;
         got.changed = data[0];
         got.valid   = data[1];
         got.idx     = data[4:2];
         got.fast    = data[20:5];
         got.fupd    = data[21];
         got.fvolt   = data[37:22];
         if (pending_steps.size() == 0) begin
            $display("%0t ns: result word %h with none expected", $time, data);
            errors++;
            return;
         end
         want = pending_steps.pop_front();
         if (want.changed) changes++;
         if (got.changed !== want.changed)
            report("changed", 16'(want.changed), 16'(got.changed));
         if (got.valid !== want.valid)
            report("step_valid", 16'(want.valid), 16'(got.valid));
         if (got.idx !== want.idx)
            report("step_index", 16'(want.idx), 16'(got.idx));
         if (got.fast !== want.fast) report("fast_current", want.fast, got.fast);
         if (got.fupd !== want.fupd)
            report("float_update", 16'(want.fupd), 16'(got.fupd));
         if (got.fvolt !== want.fvolt) report("float_voltage", want.fvolt, got.fvolt);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [79:0] req_tdata = '0;
   logic [4:0]  req_tuser = '0;
   logic        rsp_tready = 1'b0;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [39:0] rsp_tdata;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   logic steady = 1'b0;     // no idling on either side while set
   int   stall_cycles = 0;
   int   settings = 0;
   int   reloads = 0;
   charge_step_tracker tracker;

   step_charge_level_select_unit #(.MAX_STEPS(N_STEPS)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_word(rsp_tdata);
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_psel && csr_penable))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("FAIL step_charge_level_select_unit");
         $finish;
      end
   end

   function automatic logic [15:0] near(int base, int spread, int hi);
      int v;
      v = base + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > hi) v = hi;
      return v[15:0];
   endfunction

   // word with op set and every other field random
   function automatic req_word_type make_plain(logic [1:0] op);
      req_word_type w;
      w = req_word_type'({$urandom, $urandom, $urandom});
      w.soc = 10'($urandom_range(0, 1000));
      w.op = op;
      return w;
   endfunction

   function automatic req_word_type make_write(logic [2:0] sel, int index, int value);
      req_word_type w;
      w = make_plain(OP_WRITE);
      w.sel = sel;
      w.idx = index[2:0];
      w.value = value[15:0];
      return w;
   endfunction

   function automatic req_word_type make_check(logic [15:0] power, logic cable,
      logic [15:0] volt, logic [15:0] current, logic [9:0] soc, logic noswell);
      req_word_type w;
      w = make_plain(OP_CHECK);
      w.power = power;
      w.cable = cable;
      w.volt = volt;
      w.current = current;
      w.soc = soc;
      w.noswell = noswell;
      return w;
   endfunction

   // check values clustered around the thresholds of a random step
   function automatic req_word_type random_check();
      req_word_type w;
      int k, r;
      k = $urandom_range(0, N_STEPS - 1);
      w = make_plain(OP_CHECK);
      if ($urandom_range(0, 99) < 70) w.volt = near(int'(tracker.volt_lim[k]) - 20, 4, 65535);
      r = $urandom_range(0, 99);
      if (r < 60) w.current = near(int'(tracker.cur_lim[k]), 4, 65535);
      else if (r < 75) w.current = 16'h8000 | 16'($urandom);
      if ($urandom_range(0, 99) < 70) w.soc = near(int'(tracker.soc_lim[k]), 3, 1000);
      r = $urandom_range(0, 99);
      if (r < 60) w.power = 16'($urandom_range(int'(tracker.power_thr), 65535));
      else if (r < 80) w.power = near(int'(tracker.power_thr), 2, 65535);
      w.cable = ($urandom_range(0, 99) < 85);
      return w;
   endfunction

   task automatic send_word(req_word_type w);
      if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= {w.sel, w.op};
      req_tdata <= {1'b0, w.noswell, w.soc, w.current, w.volt, w.cable, w.power, w.value, w.idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_word(w);
   endtask

   task automatic write_reg(logic [1:0] index, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      tracker.set_reg(index, val);
      @(posedge clock);
   endtask

   // wait for every expected word, then let the walk settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_steps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic [6:0] mode, logic [15:0] thr, logic [3:0] cnt);
      drain();
      write_reg(REG_MODE, {25'd0, mode});
      write_reg(REG_POWER_THR, {16'd0, thr});
      write_reg(REG_STEP_CNT, {28'd0, cnt});
      settings++;
   endtask

   // rewrite all five tables; ordered gives thresholds that walk step by step
   task automatic load_profile(bit ordered);
      int v, a, s;
      v = $urandom_range(3300, 3700);
      a = $urandom_range(2500, 4000);
      s = $urandom_range(0, 100);
      for (int i = 0; i < N_STEPS; i++) begin
         if (ordered) begin
            send_word(make_write(TBL_VOLTAGE, i, v));
            send_word(make_write(TBL_CURRENT, i, a));
            send_word(make_write(TBL_SOC, i, s));
            send_word(make_write(TBL_FAST, i, $urandom_range(500, 4500)));
            send_word(make_write(TBL_FLOAT, i, $urandom_range(4000, 4450)));
            v += $urandom_range(10, 120);
            a -= $urandom_range(50, 400);
            if (a < 100) a = 100;
            s += $urandom_range(20, 120);
         end else begin
            send_word(make_write(TBL_VOLTAGE, i, $urandom));
            send_word(make_write(TBL_CURRENT, i, $urandom));
            send_word(make_write(TBL_SOC, i, $urandom));
            send_word(make_write(TBL_FAST, i, $urandom));
            send_word(make_write(TBL_FLOAT, i, $urandom));
         end
      end
      reloads++;
   endtask

   initial begin
      int phase, items, r;
      logic [6:0] mode;
      logic [15:0] thr;
      logic [3:0] cnt;
      req_word_type w;

      tracker = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // every table entry is written before any check reads it
      load_profile(1'b1);

      configure(MODE_VOLTAGE | MODE_CURRENT | MODE_SOC | MODE_FLOAT, 16'd0, 4'd8);
      send_word(make_check(16'd0, 1'b0, 16'd0, 16'd0, 10'd0, 1'b1));       // stop at step 0
      send_word(make_check(16'd0, 1'b0, 16'd0, 16'd0, 10'd0, 1'b1));       // no change
      send_word(make_check(16'hFFFF, 1'b1, 16'hFFFF, 16'd0, 10'd1000, 1'b1)); // one step up
      send_word(make_plain(OP_RESET));
      send_word(make_check(16'hFFFF, 1'b1, 16'hFFFF, 16'd0, 10'd1000, 1'b0)); // full walk
      send_word(make_check(16'hFFFF, 1'b1, 16'hFFFF, 16'h8000, 10'd1000, 1'b1));
      send_word(make_plain(OP_RESET));
      // most negative current stops the current walk at once
      send_word(make_check(16'hFFFF, 1'b1, 16'hFFFF, 16'h8000, 10'd1000, 1'b1));
      send_word(make_check(16'hFFFF, 1'b1, 16'hFFFF, 16'h7FFF, 10'd1000, 1'b1));
      send_word(make_plain(OP_IDLE));
      send_word(make_write(3'd5, 7, 16'hFFFF));                           // ignored selects
      send_word(make_write(3'd7, 0, 16'h0000));
      send_word(make_write(TBL_FAST, 0, 16'hFFFF));
      send_word(make_write(TBL_FLOAT, 0, 16'hFFFF));
      send_word(make_plain(OP_RESET));
      send_word(make_check(16'd0, 1'b0, 16'd0, 16'd0, 10'd0, 1'b1));

      // all bits set, step count beyond the table saturates
      configure(7'h7F, 16'hFFFF, 4'hF);
      send_word(make_plain(OP_RESET));
      send_word(make_check(16'hFFFE, 1'b1, 16'hFFFF, 16'd0, 10'd1000, 1'b1));  // power gate
      send_word(make_check(16'hFFFF, 1'b0, 16'hFFFF, 16'd0, 10'd1000, 1'b1));  // cable gate
      send_word(make_check(16'hFFFF, 1'b1, 16'hFFFF, 16'd0, 10'd1000, 1'b1));

      // gates only, no criterion
      configure(MODE_POWER | MODE_CABLE | MODE_FLOAT, 16'd0, 4'd8);
      send_word(make_plain(OP_RESET));
      send_word(make_check(16'hFFFF, 1'b1, 16'hFFFF, 16'd0, 10'd1000, 1'b1));

      configure(MODE_VOLTAGE, 16'd0, 4'd0);
      send_word(make_check(16'd0, 1'b0, 16'hFFFF, 16'd0, 10'd0, 1'b1));
      send_word(make_check(16'd0, 1'b0, 16'hFFFF, 16'd0, 10'd0, 1'b1));
      configure(7'd0, POWER_THR_RESET, 4'd1);
      send_word(make_check(16'hFFFF, 1'b1, 16'hFFFF, 16'd0, 10'd1000, 1'b1));
      configure(MODE_SOC, POWER_THR_RESET, 4'd1);
      send_word(make_plain(OP_RESET));
      send_word(make_check(16'hFFFF, 1'b1, 16'hFFFF, 16'd0, 10'd1000, 1'b1));

      phase = 0;
      while (tracker.words < RANDOM_WORDS) begin
         mode = 7'($urandom_range(0, 127));
         if ($urandom_range(0, 99) >= 10 && (mode & MODE_ANY_CRIT) == '0) mode |= MODE_VOLTAGE;
         r = $urandom_range(0, 99);
         if (r < 15) thr = 16'd0;
         else if (r < 25) thr = 16'hFFFF;
         else if (r < 40) thr = POWER_THR_RESET;
         else thr = 16'($urandom_range(0, 30000));
         r = $urandom_range(0, 99);
         if (r < 10) cnt = 4'($urandom_range(0, 1));
         else if (r < 18) cnt = 4'($urandom_range(9, 15));
         else cnt = 4'($urandom_range(2, 8));
         steady = (phase >= 6 && phase < 10);
         configure(mode, thr, cnt);
         if ($urandom_range(0, 99) < 25) load_profile($urandom_range(0, 99) < 80);
         items = $urandom_range(30, 90);
         for (int n = 0; n < items; n++) begin
            r = $urandom_range(0, 99);
            if (r < 7) w = make_plain(OP_RESET);
            else if (r < 11)
               w = make_write(3'($urandom_range(0, 7)), int'($urandom_range(0, 7)),
                              int'($urandom));
            else if (r < 14) w = make_plain(OP_IDLE);
            else w = random_check();
            send_word(w);
         end
         phase++;
      end
      steady = 1'b0;

      drain();
      $display("Ran %0d words (%0d checks, %0d step changes) over %0d register settings,",
               tracker.words, tracker.checks, tracker.changes, settings);
      $display("with %0d table reloads and %0d mismatches.", reloads, tracker.errors);
      if (tracker.errors == 0)
         $display("PASS step_charge_level_select_unit");
      else
         $display("FAIL step_charge_level_select_unit");
      $finish;
   end

endmodule
